@@ rtl/slpbs_pkg.sv @@
// Package for the status LED priority and burst sequencer.
// Holds the item types, the pattern, mode, power state and register codes, the reset values and the burst tables.
// No dependencies.
package slpbs_pkg;

    localparam int NUM_BURSTS = 4;

    // Pattern codes.
    localparam logic [2:0] PAT_OFF   = 3'd0;
    localparam logic [2:0] PAT_SOLID = 3'd1;
    localparam logic [2:0] PAT_HEART = 3'd2;
    localparam logic [2:0] PAT_AMBER = 3'd3;
    localparam logic [2:0] PAT_ALERT = 3'd4;

    // Mode codes.
    localparam logic [2:0] MODE_AUTO    = 3'd0;
    localparam logic [2:0] MODE_PROV    = 3'd1;
    localparam logic [2:0] MODE_CONN    = 3'd2;
    localparam logic [2:0] MODE_ONLINE  = 3'd3;

    // Power state codes.
    localparam logic [1:0] PWR_NORMAL = 2'd0;
    localparam logic [1:0] PWR_WARN   = 2'd1;
    localparam logic [1:0] PWR_CRIT   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CRIT_BRIGHTNESS = 3'd0;
    localparam logic [2:0] CFG_WARN_BRIGHTNESS = 3'd1;
    localparam logic [2:0] CFG_IDLE_BRIGHTNESS = 3'd2;
    localparam logic [2:0] CFG_DEFAULT_HOLD    = 3'd3;
    localparam logic [2:0] CFG_BEACON_ENABLE   = 3'd4;

    // Configuration reset values.
    localparam logic [7:0]  RST_CRIT_BRIGHTNESS = 8'd255;
    localparam logic [7:0]  RST_WARN_BRIGHTNESS = 8'd128;
    localparam logic [7:0]  RST_IDLE_BRIGHTNESS = 8'd32;
    localparam logic [15:0] RST_DEFAULT_HOLD    = 16'd3000;

    localparam logic [7:0]  HEART_LEVEL = 8'd48;
    localparam logic [23:0] COLOR_PROV  = 24'h8CFF00;
    localparam logic [23:0] COLOR_CONN  = 24'h9640FF;

    // Burst tables, one entry per burst: fault, battery critical, battery low, beacon.
    localparam logic [1:0]  BURST_PULSES [NUM_BURSTS] = '{2'd2, 2'd3, 2'd3, 2'd1};
    localparam logic [31:0] BURST_ON_MS  [NUM_BURSTS] = '{32'd300, 32'd150, 32'd100, 32'd80};
    // Pulse on-time plus gap.
    localparam logic [31:0] BURST_STEP_MS [NUM_BURSTS] =
        '{32'd600, 32'd300, 32'd250, 32'd80};
    localparam logic [31:0] BURST_PERIOD_MS [NUM_BURSTS] =
        '{32'd5000, 32'd12000, 32'd60000, 32'd30000};
    localparam logic [23:0] BURST_COLOR [NUM_BURSTS] =
        '{24'h00FF00, 24'h20FF00, 24'hC8FF00, 24'hDC4060};

    typedef struct packed {
        logic [31:0] now_ms;
        logic        fault_active;
        logic [2:0]  mode;
        logic        power_valid;
        logic [1:0]  power_state;
        logic [7:0]  brightness_limit;
        logic        override_req;
        logic [2:0]  override_pattern;
        logic [23:0] override_color;
        logic [7:0]  override_brightness;
        logic [31:0] override_hold_ms;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  led_pattern;
        logic [23:0] led_color;
        logic [7:0]  led_brightness;
        logic        led_update;
    } out_item_t;

endpackage

@@ rtl/status_led_priority_burst_sequencer_top.sv @@
// Status LED priority and burst sequencer, top level.
// Takes tick items, resolves the LED priority, runs the pulse bursts and the override.
// Depends on slpbs_pkg.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one tick item. Output channel
//   (out_valid, out_stall, out_data) returns exactly one result item per tick item.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data; the port
//   is always ready and must only be used while no item is in flight.
// Pipeline and throughput:
//   An item is registered in the input register on acceptance; its result is
//   registered in the result register when the item advances. One item per cycle
//   is sustained while out_stall is low: the whole decision is one pass of logic
//   between the two registers, and the burst lanes update in that same pass.
// Reset:
//   All bursts are idle and due at once, no override is held, the shown LED is off
//   and the registers take their reset values (255, 128, 32, 3000 ms, beacon on).
// Stalls:
//   While out_stall is high a result stays on the output; one further item can be
//   taken into the input register, after which in_stall rises until the result
//   leaves.
module status_led_priority_burst_sequencer_top
    import slpbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [2:0] {
        PRI_FAULT, PRI_CRIT, PRI_LOW, PRI_BEACON, PRI_PROV, PRI_CONN, PRI_OFF
    } pri_t;

    // Configuration registers.
    logic [7:0]  crit_bright_reg, warn_bright_reg, idle_bright_reg;
    logic [15:0] default_hold_reg;
    logic        beacon_en_reg;

    // Pipeline control and payload.
    logic      s1_valid_reg, out_valid_reg;
    in_item_t  in_data_reg;
    out_item_t out_data_reg, out_data_next;

    // Burst lanes.
    logic        burst_run_reg   [NUM_BURSTS];
    logic [1:0]  pulses_left_reg [NUM_BURSTS];
    logic [31:0] next_pulse_reg  [NUM_BURSTS];
    logic [31:0] next_burst_reg  [NUM_BURSTS];
    logic        burst_run_next   [NUM_BURSTS];
    logic [1:0]  pulses_left_next [NUM_BURSTS];
    logic [31:0] next_pulse_next  [NUM_BURSTS];
    logic [31:0] next_burst_next  [NUM_BURSTS];

    // Override and shown state.
    logic        ovr_on_reg, ovr_on_next;
    logic [31:0] ovr_end_reg, ovr_end_next;
    logic [2:0]  held_pat_reg, held_pat_next;
    logic [23:0] held_col_reg, held_col_next;
    logic [7:0]  held_bri_reg, held_bri_next;
    logic [2:0]  shown_pat_reg, shown_pat_next;
    logic [23:0] shown_col_reg, shown_col_next;
    logic [7:0]  shown_bri_reg, shown_bri_next;

    logic advance;
    logic in_accept;

    // Combinational working signals.
    logic [31:0] now;
    logic [7:0]  limit;
    logic [2:0]  req_pat;
    logic [7:0]  req_bri;
    logic [31:0] hold_dur;
    logic [31:0] ovr_diff;
    logic        ovr_live;
    logic [1:0]  pstate;
    pri_t        pri;
    logic [3:0]  pri_lane;
    logic [7:0]  lane_level [NUM_BURSTS];

    logic        base_run   [NUM_BURSTS];
    logic [1:0]  base_left  [NUM_BURSTS];
    logic [31:0] base_pulse [NUM_BURSTS];
    logic [31:0] base_burst [NUM_BURSTS];
    logic        lane_start [NUM_BURSTS];
    logic        lane_act   [NUM_BURSTS];
    logic [1:0]  lane_left  [NUM_BURSTS];
    logic        lane_due   [NUM_BURSTS];
    logic        lane_fire  [NUM_BURSTS];
    logic [1:0]  lane_left_new [NUM_BURSTS];
    logic [32:0] lane_step_sum [NUM_BURSTS];
    logic [31:0] lane_pulse_new [NUM_BURSTS];
    logic        lane_done  [NUM_BURSTS];
    logic        lane_en    [NUM_BURSTS];
    logic [3:0]  fire_vec;
    logic        fired;

    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        now   = in_data_reg.now_ms;
        limit = in_data_reg.brightness_limit;

        // Commanded override: undefined patterns fall back to off.
        req_pat  = (in_data_reg.override_pattern > PAT_ALERT) ? PAT_OFF
                                                                : in_data_reg.override_pattern;
        req_bri  = (in_data_reg.override_brightness > limit) ? limit
                                                              : in_data_reg.override_brightness;
        hold_dur = (in_data_reg.override_hold_ms != 32'd0) ? in_data_reg.override_hold_ms
                                                             : {16'd0, default_hold_reg};
        // A fresh request leaves exactly its hold time until expiry.
        ovr_diff = in_data_reg.override_req ? hold_dur : (ovr_end_reg - now);
        ovr_live = (in_data_reg.override_req || ovr_on_reg)
                   && !(ovr_diff == 32'd0 || ovr_diff[31]);

        pstate = in_data_reg.power_valid ? in_data_reg.power_state : PWR_NORMAL;
        if (in_data_reg.fault_active)
            pri = PRI_FAULT;
        else if (pstate == PWR_CRIT)
            pri = PRI_CRIT;
        else if (pstate == PWR_WARN)
            pri = PRI_LOW;
        else if (in_data_reg.mode == MODE_PROV)
            pri = PRI_PROV;
        else if (in_data_reg.mode == MODE_CONN)
            pri = PRI_CONN;
        else if (pstate == PWR_NORMAL && (in_data_reg.mode == MODE_ONLINE
                                          || in_data_reg.mode == MODE_AUTO))
            pri = PRI_BEACON;
        else
            pri = PRI_OFF;

        case (pri)
            PRI_FAULT:  pri_lane = 4'b0001;
            PRI_CRIT:   pri_lane = 4'b0010;
            PRI_LOW:    pri_lane = 4'b0100;
            PRI_BEACON: pri_lane = 4'b1000;
            default:    pri_lane = 4'b0000;
        endcase

        lane_level[0] = crit_bright_reg;
        lane_level[1] = crit_bright_reg;
        lane_level[2] = warn_bright_reg;
        lane_level[3] = idle_bright_reg;

        for (int k = 0; k < NUM_BURSTS; k++)
        begin
            // The fault burst is held cleared while no fault is present.
            if (k == 0 && !in_data_reg.fault_active)
            begin
                base_run[k]   = 1'b0;
                base_left[k]  = 2'd0;
                base_pulse[k] = 32'd0;
                base_burst[k] = 32'd0;
            end
            else
            begin
                base_run[k]   = burst_run_reg[k];
                base_left[k]  = pulses_left_reg[k];
                base_pulse[k] = next_pulse_reg[k];
                base_burst[k] = next_burst_reg[k];
            end

            lane_start[k] = !base_run[k] && (base_burst[k] == 32'd0 || now >= base_burst[k]);
            lane_act[k]   = base_run[k] || lane_start[k];
            lane_left[k]  = lane_start[k] ? BURST_PULSES[k] : base_left[k];
            lane_due[k]   = lane_start[k] || (now >= base_pulse[k]);
            lane_fire[k]  = lane_act[k] && (lane_left[k] != 2'd0) && lane_due[k];
            lane_left_new[k] = lane_fire[k] ? (lane_left[k] - 2'd1) : lane_left[k];
            lane_step_sum[k] = {1'b0, now} + {1'b0, BURST_STEP_MS[k]};
            if (lane_fire[k])
                lane_pulse_new[k] = lane_step_sum[k][31:0];
            else if (lane_start[k])
                lane_pulse_new[k] = now;
            else
                lane_pulse_new[k] = base_pulse[k];
            // After a pulse, the next pulse time is already past only if the sum wrapped.
            lane_done[k] = lane_act[k] && (lane_left_new[k] == 2'd0)
                           && (lane_fire[k] ? lane_step_sum[k][32] : lane_due[k]);

            lane_en[k] = !ovr_live && pri_lane[k] && (k != 3 || beacon_en_reg);
            fire_vec[k] = lane_en[k] && lane_fire[k];

            if (ovr_live || (pri_lane[k] && !lane_en[k]))
            begin
                burst_run_next[k]   = base_run[k];
                pulses_left_next[k] = base_left[k];
                next_pulse_next[k]  = base_pulse[k];
                next_burst_next[k]  = base_burst[k];
            end
            else if (lane_en[k])
            begin
                burst_run_next[k]   = lane_act[k] && !lane_done[k];
                pulses_left_next[k] = lane_act[k] ? lane_left_new[k] : base_left[k];
                next_pulse_next[k]  = lane_act[k] ? lane_pulse_new[k] : base_pulse[k];
                next_burst_next[k]  = lane_done[k] ? (now + BURST_PERIOD_MS[k])
                                                   : base_burst[k];
            end
            else
            begin
                burst_run_next[k]   = 1'b0;
                pulses_left_next[k] = 2'd0;
                next_pulse_next[k]  = 32'd0;
                next_burst_next[k]  = 32'd0;
            end
        end

        fired = |fire_vec;

        // Held override after any request on this tick.
        if (in_data_reg.override_req)
        begin
            held_pat_next = req_pat;
            held_col_next = in_data_reg.override_color;
            held_bri_next = req_bri;
            ovr_end_next  = now + hold_dur;
        end
        else
        begin
            held_pat_next = held_pat_reg;
            held_col_next = held_col_reg;
            held_bri_next = held_bri_reg;
            ovr_end_next  = ovr_end_reg;
        end
        ovr_on_next = ovr_live;

        if (ovr_live)
        begin
            shown_pat_next = held_pat_next;
            shown_col_next = held_col_next;
            shown_bri_next = (held_bri_next > limit) ? limit : held_bri_next;
        end
        else if (fired)
        begin
            // A firing pulse becomes the held override for its on-time.
            ovr_on_next    = 1'b1;
            held_pat_next  = PAT_SOLID;
            held_col_next  = BURST_COLOR[pri[1:0]];
            held_bri_next  = lane_level[pri[1:0]];
            ovr_end_next   = now + BURST_ON_MS[pri[1:0]];
            shown_pat_next = PAT_SOLID;
            shown_col_next = BURST_COLOR[pri[1:0]];
            shown_bri_next = (lane_level[pri[1:0]] > limit) ? limit : lane_level[pri[1:0]];
        end
        else if (pri == PRI_PROV)
        begin
            shown_pat_next = PAT_HEART;
            shown_col_next = COLOR_PROV;
            shown_bri_next = (HEART_LEVEL > limit) ? limit : HEART_LEVEL;
        end
        else if (pri == PRI_CONN)
        begin
            shown_pat_next = PAT_HEART;
            shown_col_next = COLOR_CONN;
            shown_bri_next = (HEART_LEVEL > limit) ? limit : HEART_LEVEL;
        end
        else
        begin
            shown_pat_next = PAT_OFF;
            shown_col_next = 24'd0;
            shown_bri_next = 8'd0;
        end
        if (shown_pat_next == PAT_OFF)
            shown_bri_next = 8'd0;

        out_data_next.led_pattern    = shown_pat_next;
        out_data_next.led_color      = shown_col_next;
        out_data_next.led_brightness = shown_bri_next;
        out_data_next.led_update     = (shown_pat_next != shown_pat_reg)
                                       || (shown_col_next != shown_col_reg)
                                       || (shown_bri_next != shown_bri_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crit_bright_reg  <= RST_CRIT_BRIGHTNESS;
            warn_bright_reg  <= RST_WARN_BRIGHTNESS;
            idle_bright_reg  <= RST_IDLE_BRIGHTNESS;
            default_hold_reg <= RST_DEFAULT_HOLD;
            beacon_en_reg    <= 1'b1;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int k = 0; k < NUM_BURSTS; k++)
            begin
                burst_run_reg[k]   <= 1'b0;
                pulses_left_reg[k] <= 2'd0;
                next_pulse_reg[k]  <= 32'd0;
                next_burst_reg[k]  <= 32'd0;
            end
            ovr_on_reg    <= 1'b0;
            ovr_end_reg   <= 32'd0;
            held_pat_reg  <= PAT_OFF;
            held_col_reg  <= 24'd0;
            held_bri_reg  <= 8'd0;
            shown_pat_reg <= PAT_OFF;
            shown_col_reg <= 24'd0;
            shown_bri_reg <= 8'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CRIT_BRIGHTNESS: crit_bright_reg  <= cfg_data[7:0];
                    CFG_WARN_BRIGHTNESS: warn_bright_reg  <= cfg_data[7:0];
                    CFG_IDLE_BRIGHTNESS: idle_bright_reg  <= cfg_data[7:0];
                    CFG_DEFAULT_HOLD:    default_hold_reg <= cfg_data;
                    CFG_BEACON_ENABLE:   beacon_en_reg    <= cfg_data[0];
                    default: ;
                endcase
            end

            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                for (int k = 0; k < NUM_BURSTS; k++)
                begin
                    burst_run_reg[k]   <= burst_run_next[k];
                    pulses_left_reg[k] <= pulses_left_next[k];
                    next_pulse_reg[k]  <= next_pulse_next[k];
                    next_burst_reg[k]  <= next_burst_next[k];
                end
                ovr_on_reg    <= ovr_on_next;
                ovr_end_reg   <= ovr_end_next;
                held_pat_reg  <= held_pat_next;
                held_col_reg  <= held_col_next;
                held_bri_reg  <= held_bri_next;
                shown_pat_reg <= shown_pat_next;
                shown_col_reg <= shown_col_next;
                shown_bri_reg <= shown_bri_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.led_pattern == PAT_OFF |-> out_data.led_brightness == 8'd0)
        else $error("LED off but brightness is not zero");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("Input stalled with no item held");

    a_fault_burst_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_data_reg.fault_active |=> !burst_run_reg[0])
        else $error("Fault burst still running after a tick without fault");
`endif

endmodule
